>>> hw/rtl/html_text_escaper_core_defines.svh
// Assertion macros shared by the escaper's checker.
// Needs clk and rst_n visible in the scope where a macro is used.
`ifndef HTML_TEXT_ESCAPER_CORE_DEFINES_SVH
`define HTML_TEXT_ESCAPER_CORE_DEFINES_SVH

// Checked only while out of reset
`define HTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define HTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/hte_pkg.sv
// Shared types and constants for the HTML text escaper.
// No dependencies.
`default_nettype none

package hte_pkg;

  localparam int IN_CHAR_W  = 16;
  localparam int LEN_W      = 4;   // longest run is 11 characters
  localparam int CFG_IDX_W  = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENCODE_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_MODE     = 1'd1;

  localparam logic [IN_CHAR_W-1:0] NUM_ENTITY_MIN = 16'd160;

  // Characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // What the back end emits for one queued item
  typedef enum logic [2:0] {
    K_PASS,
    K_NBSP,
    K_QUOT,
    K_AMP,
    K_LT,
    K_GT,
    K_BR,
    K_NUM
  } kind_t;

  typedef struct packed {
    logic [IN_CHAR_W-1:0] in_char;
    logic                 last_in_chunk;
  } in_beat_t;

  typedef struct packed {
    logic [IN_CHAR_W-1:0] out_char;
    logic                 run_last;
  } out_beat_t;

  typedef struct packed {
    kind_t                kind;
    logic [IN_CHAR_W-1:0] code;
    logic [LEN_W-1:0]     len;
  } q_entry_t;

  typedef struct packed {
    logic encode_enable;
    logic byte_mode;
  } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/hte_front.sv
// Front end: accepts input beats, classifies each character and tracks the blank flag.
// Depends on hte_pkg.
`default_nettype none

module hte_front import hte_pkg::*; #(
  parameter int CHAR_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_beat_t in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output q_entry_t      q_entry
);

  localparam int CODE_W = (CHAR_BITS < IN_CHAR_W) ? CHAR_BITS : IN_CHAR_W;
  localparam logic [IN_CHAR_W-1:0] CODE_MASK = IN_CHAR_W'((64'd1 << CODE_W) - 64'd1);

  logic                 prev_blank_r, prev_blank_nxt;
  logic                 accept;
  logic [IN_CHAR_W-1:0] code;
  kind_t                kind;
  logic [LEN_W-1:0]     len;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  // Mask to the character width, then to the byte lane in byte mode
  always_comb begin
    code = in_data.in_char & CODE_MASK;
    if (cfg.byte_mode) begin
      code = code & IN_CHAR_W'(8'hFF);
    end
  end

  // Classify and update the blank flag
  always_comb begin
    kind           = K_PASS;
    len            = LEN_W'(1);
    prev_blank_nxt = prev_blank_r;
    if (cfg.encode_enable) begin
      prev_blank_nxt = 1'b0;
      if (code == IN_CHAR_W'(CH_SPACE)) begin
        if (prev_blank_r) begin
          kind = K_NBSP;
          len  = LEN_W'(6);
        end else begin
          prev_blank_nxt = 1'b1;
        end
      end else if (code == IN_CHAR_W'(CH_QUOT)) begin
        kind = K_QUOT;
        len  = LEN_W'(6);
      end else if (code == IN_CHAR_W'(CH_AMP)) begin
        kind = K_AMP;
        len  = LEN_W'(5);
      end else if (code == IN_CHAR_W'(CH_LT)) begin
        kind = K_LT;
        len  = LEN_W'(4);
      end else if (code == IN_CHAR_W'(CH_GT)) begin
        kind = K_GT;
        len  = LEN_W'(4);
      end else if (code == IN_CHAR_W'(CH_NL)) begin
        kind = K_BR;
        len  = LEN_W'(11);
      end else if (!cfg.byte_mode && code >= NUM_ENTITY_MIN) begin
        // "&#" + 3..5 digits + ";"
        kind = K_NUM;
        if (code >= IN_CHAR_W'(10000)) begin
          len = LEN_W'(8);
        end else if (code >= IN_CHAR_W'(1000)) begin
          len = LEN_W'(7);
        end else begin
          len = LEN_W'(6);
        end
      end
    end
    if (in_data.last_in_chunk) begin
      prev_blank_nxt = 1'b0;
    end
  end

  assign q_entry = '{kind: kind, code: code, len: len};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_blank_r <= 1'b0;
    end else if (accept) begin
      prev_blank_r <= prev_blank_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hte_queue.sv
// Small FIFO of classified items between the front and back ends.
// Depends on hte_pkg.
`default_nettype none

module hte_queue import hte_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_data,
  input  wire logic     pop,
  output logic          full,
  output logic          not_empty,
  output q_entry_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hte_back.sv
// Back end: expands the queue head into its run of characters, one per cycle unless out_stall holds the output.
// Depends on hte_pkg.
`default_nettype none

module hte_back import hte_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  input  wire q_entry_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_beat_t     out_data
);

  localparam logic [47:0] TXT_NBSP = "&nbsp;";
  localparam logic [47:0] TXT_QUOT = "&quot;";
  localparam logic [39:0] TXT_AMP  = "&amp;";
  localparam logic [31:0] TXT_LT   = "&lt;";
  localparam logic [31:0] TXT_GT   = "&gt;";
  localparam logic [87:0] TXT_BR   = "&lt;br/&gt;";

  logic [LEN_W-1:0]     idx_r, idx_nxt;
  logic [IN_CHAR_W-1:0] rem_r, rem_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_beat_t            out_data_r, out_data_nxt;

  logic                 emit;
  logic                 run_end;
  logic [IN_CHAR_W-1:0] cur_rem;
  logic [2:0]           pos;
  logic [16:0]          pow;
  logic [16:0]          thr;
  logic [16:0]          sub;
  logic [3:0]           digit;
  logic [7:0]           txt;
  logic [IN_CHAR_W-1:0] ch;

  // Character idx of a fixed entity string
  function automatic logic [7:0] txt_char(kind_t k, logic [LEN_W-1:0] i);
    logic [7:0] c;
    c = CH_SEMI;
    case (k)
      K_NBSP:  c = TXT_NBSP[8*(5 - int'(i)) +: 8];
      K_QUOT:  c = TXT_QUOT[8*(5 - int'(i)) +: 8];
      K_AMP:   c = TXT_AMP[8*(4 - int'(i)) +: 8];
      K_LT:    c = TXT_LT[8*(3 - int'(i)) +: 8];
      K_GT:    c = TXT_GT[8*(3 - int'(i)) +: 8];
      K_BR:    c = TXT_BR[8*(10 - int'(i)) +: 8];
      default: c = CH_SEMI;
    endcase
    return c;
  endfunction

  assign emit    = q_valid && (!out_valid_r || !out_stall);
  assign run_end = (idx_r == q_head.len - LEN_W'(1));
  assign q_pop   = emit && run_end;

  // Decimal digit: the first digit starts from the stored code
  assign cur_rem = (idx_r == LEN_W'(2)) ? q_head.code : rem_r;
  assign pos     = 3'(q_head.len - LEN_W'(2) - idx_r);

  always_comb begin
    case (pos)
      3'd0:    pow = 17'd1;
      3'd1:    pow = 17'd10;
      3'd2:    pow = 17'd100;
      3'd3:    pow = 17'd1000;
      3'd4:    pow = 17'd10000;
      default: pow = 17'd1;
    endcase
  end

  // Largest multiple of the place value that fits
  always_comb begin
    digit = '0;
    sub   = '0;
    thr   = '0;
    for (int k = 1; k <= 9; k++) begin
      thr = 17'(pow * 17'(k));
      if ({1'b0, cur_rem} >= thr) begin
        digit = 4'(k);
        sub   = thr;
      end
    end
    rem_nxt = cur_rem - sub[IN_CHAR_W-1:0];
  end

  // Character for this step of the run
  always_comb begin
    txt = txt_char(q_head.kind, idx_r);
    case (q_head.kind)
      K_PASS: ch = q_head.code;
      K_NUM: begin
        if (idx_r == LEN_W'(0)) begin
          ch = IN_CHAR_W'(CH_AMP);
        end else if (idx_r == LEN_W'(1)) begin
          ch = IN_CHAR_W'(CH_HASH);
        end else if (run_end) begin
          ch = IN_CHAR_W'(CH_SEMI);
        end else begin
          ch = IN_CHAR_W'(CH_ZERO) + IN_CHAR_W'(digit);
        end
      end
      default: ch = IN_CHAR_W'(txt);
    endcase
  end

  // Output register and run counter
  always_comb begin
    idx_nxt       = idx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{out_char: ch, run_last: run_end};
      idx_nxt       = run_end ? '0 : idx_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (emit) begin
      rem_r <= rem_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/html_text_escaper_core.sv
// HTML text escaper top level: configuration registers, front end, queue, back end.
// Depends on hte_pkg, hte_front, hte_queue and hte_back.
//
// Usage:
//   in_*  : one character per beat (in_data.in_char, in_data.last_in_chunk); a beat is
//           taken when in_valid is high and in_stall is low.
//   out_* : one escaped character per beat; out_data.run_last marks the final
//           character of each input's run. The sink holds out_stall high to wait.
//   cfg_* : cfg_we writes cfg_wdata to register cfg_index (0 encode_enable,
//           1 byte_mode); write only while the block is idle.
// An accepted item is written into the queue; its first output character is then loaded
// from the queue head into the output register.
// The back end emits one character per cycle while out_stall is low; an item's run is
// 1 character for a plain character and up to 11 for a newline.
// The queue between front and back holds QUEUE_DEPTH items; in_stall rises only
// when it is full. A stalled output holds its beat, and the back end waits.
// Reset (rst_n low, synchronous) empties the queue and the output register, clears
// the blank flag and sets encode_enable = 1, byte_mode = 0.
`default_nettype none

module html_text_escaper_core import hte_pkg::*; #(
  parameter int CHAR_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_beat_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_beat_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic                 cfg_wdata
);

  cfg_t     cfg_r, cfg_nxt;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_valid;
  q_entry_t q_in;
  q_entry_t q_head;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ENCODE_ENABLE: cfg_nxt.encode_enable = cfg_wdata;
        REG_BYTE_MODE:     cfg_nxt.byte_mode     = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{encode_enable: 1'b1, byte_mode: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hte_front #(
    .CHAR_BITS (CHAR_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  hte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  hte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> hw/rtl/hte_checker.sv
// Port-level checker for the HTML text escaper, bound to its top level.
// Depends on hte_pkg and html_text_escaper_core_defines.svh.
`default_nettype none

`include "html_text_escaper_core_defines.svh"

module hte_checker import hte_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_beat_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_beat_t out_data
);

  // A stalled output beat stays put
  `HTE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "output beat changed while stalled")

  // A stalled input beat stays put
  `HTE_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable(in_data), "input beat changed while stalled")

  // Reset empties the output register
  `HTE_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid, "output valid right after reset")

  // A run continues without a gap until its last character
  `HTE_ASSERT(a_run_cont, out_valid && !out_stall && !out_data.run_last |=> out_valid, "gap inside an escaped run")

  // Input backs up only behind pending output
  `HTE_ASSERT(a_stall_cause, in_stall |-> out_valid, "input stalled with no output pending")

endmodule

bind html_text_escaper_core hte_checker u_hte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
